/* rtl/ita_pkg.sv */
package ita_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_BITS = 64;
    localparam int CHAR_BITS  = 8;
    localparam int PREC_BITS  = 7;
    localparam int COUNT_BITS = 3;
    localparam int LEN_BITS   = 7;
    localparam int NUM_CHARS  = 4;

    // Defaults for the top-level parameters
    localparam int DEF_VALUE_WIDTH      = 64;
    localparam int DEF_MAX_PRECISION    = 64;
    localparam int DEF_CHARS_PER_RESULT = 4;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] ASCII_X     = 8'h78;
    localparam logic [CHAR_BITS-1:0] ASCII_B     = 8'h62;

    localparam logic [CHAR_BITS-1:0] DIGITS_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [CHAR_BITS-1:0] DIGITS_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        BASE_DEC  = 2'd0,
        BASE_HEX  = 2'd1,
        BASE_BIN  = 2'd2,
        BASE_NONE = 2'd3
    } base_t;

    // Classified conversion request
    typedef struct packed {
        logic [VALUE_BITS-1:0] magnitude;
        base_t                 base;
        logic [PREC_BITS-1:0]  prec;
        logic                  neg;
        logic                  prefix;
        logic                  upper;
    } cmd_t;

endpackage

/* rtl/ita_item_if.sv */
interface ita_item_if;
    import ita_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            base_select;
    logic [PREC_BITS-1:0]  precision;
    logic                  dec_unsigned;
    logic                  add_prefix;
    logic                  uppercase;

    modport source (
        output valid, value, base_select, precision, dec_unsigned, add_prefix, uppercase,
        input  ready
    );
    modport sink (
        input  valid, value, base_select, precision, dec_unsigned, add_prefix, uppercase,
        output ready
    );
endinterface

/* rtl/ita_text_if.sv */
interface ita_text_if;
    import ita_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHAR_BITS-1:0]  char0;
    logic [CHAR_BITS-1:0]  char1;
    logic [CHAR_BITS-1:0]  char2;
    logic [CHAR_BITS-1:0]  char3;
    logic [COUNT_BITS-1:0] char_count;
    logic                  last;

    modport source (
        output valid, char0, char1, char2, char3, char_count, last,
        input  ready
    );
    modport sink (
        input  valid, char0, char1, char2, char3, char_count, last,
        output ready
    );
endinterface

/* rtl/ita_front.sv */
module ita_front #(
    parameter int VALUE_WIDTH   = ita_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_PRECISION = ita_pkg::DEF_MAX_PRECISION
) (
    ita_item_if.sink        item,
    input  logic            full,
    output ita_pkg::cmd_t   cmd,
    output logic            push
);
    import ita_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_MASK = VALUE_BITS'({VALUE_WIDTH{1'b1}});
    localparam logic [PREC_BITS-1:0]  PREC_MAX   = PREC_BITS'(MAX_PRECISION);

    logic [VALUE_BITS-1:0] masked;
    base_t                 base;
    logic                  neg;

    // Accept whenever the queue has room
    assign item.ready = !full;
    assign push       = item.valid && !full;

    // Classify: mask, sign, magnitude, saturated precision
    assign masked = item.value & VALUE_MASK;
    assign base   = base_t'(item.base_select);
    assign neg    = (base == BASE_DEC) && !item.dec_unsigned && masked[VALUE_WIDTH-1];

    always_comb
    begin
        cmd.magnitude = neg ? ((~masked + VALUE_BITS'(1)) & VALUE_MASK) : masked;
        cmd.base      = base;
        cmd.prec      = (item.precision > PREC_MAX) ? PREC_MAX : item.precision;
        cmd.neg       = neg;
        cmd.prefix    = item.add_prefix;
        cmd.upper     = item.uppercase;
    end

endmodule

/* rtl/ita_queue.sv */
module ita_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ita_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          cmd_valid,
    output ita_pkg::cmd_t rdata
);
    import ita_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign cmd_valid = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/ita_back.sv */
module ita_back #(
    parameter int VALUE_WIDTH      = ita_pkg::DEF_VALUE_WIDTH,
    parameter int CHARS_PER_RESULT = ita_pkg::DEF_CHARS_PER_RESULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ita_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    ita_text_if.source    text
);
    import ita_pkg::*;

    localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int BIT_W      = $clog2(VALUE_WIDTH);
    localparam int DCNT_W     = $clog2(DEC_DIGITS + 1);
    localparam int GROUP      = (CHARS_PER_RESULT > NUM_CHARS) ? NUM_CHARS :
                                ((CHARS_PER_RESULT < 1) ? 1 : CHARS_PER_RESULT);
    localparam logic [LEN_BITS-1:0] GROUP_LEN = LEN_BITS'(GROUP);
    localparam logic [BIT_W-1:0]    BIT_LAST  = BIT_W'(VALUE_WIDTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIZE = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    base_t                  base_reg;
    logic                   neg_reg, prefix_reg, upper_reg;
    logic [PREC_BITS-1:0]   prec_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] sh_reg;
    logic [BCD_W-1:0]       bcd_reg, bcd_adj, bcd_next;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic                   found_reg;
    logic [BIT_W-1:0]       msb_reg, cyc_reg;
    logic [LEN_BITS-1:0]    len_reg, pos_reg, lead_reg;
    logic [LEN_BITS-1:0]    len_calc, lead_calc, ndig, ndig_nat;
    logic [3:0]             dig_at_cnt;
    logic [HEX_W-1:0]       hex_val;

    logic                   ovalid_reg;
    logic [CHAR_BITS-1:0]   char_reg [NUM_CHARS];
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   last_reg;

    logic                   load_out;
    logic [LEN_BITS-1:0]    remain, cnt, pos_end;
    logic [CHAR_BITS-1:0]   grp_char [NUM_CHARS];
    logic                   grp_last;

    // Character for the digit idx places from the right end of the text
    function automatic logic [CHAR_BITS-1:0] digit_char(
        input base_t               b,
        input logic                up,
        input logic [LEN_BITS-1:0] idx,
        input logic [BCD_W-1:0]    bcd,
        input logic [HEX_W-1:0]    hv
    );
        logic [3:0]           d;
        logic                 bv;
        logic [CHAR_BITS-1:0] c;
        d  = '0;
        bv = 1'b0;
        c  = ASCII_ZERO;
        unique case (b)
            BASE_DEC:
            begin
                for (int j = 0; j < DEC_DIGITS; j++)
                begin
                    if (idx == LEN_BITS'(j))
                    begin
                        d = bcd[4*j +: 4];
                    end
                end
                c = ASCII_ZERO + CHAR_BITS'(d);
            end
            BASE_HEX:
            begin
                for (int j = 0; j < HEX_DIGITS; j++)
                begin
                    if (idx == LEN_BITS'(j))
                    begin
                        d = hv[4*j +: 4];
                    end
                end
                c = up ? DIGITS_UPPER[d] : DIGITS_LOWER[d];
            end
            BASE_BIN:
            begin
                for (int j = 0; j < HEX_W; j++)
                begin
                    if (idx == LEN_BITS'(j))
                    begin
                        bv = hv[j];
                    end
                end
                c = ASCII_ZERO + CHAR_BITS'(bv);
            end
            default:
            begin
                c = ASCII_ZERO;
            end
        endcase
        return c;
    endfunction

    assign hex_val = HEX_W'(val_reg);

    // Double-dabble step: add 3 to digits of 5 and up, then shift in the next bit
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int j = 0; j < DEC_DIGITS; j++)
        begin
            if (bcd_reg[4*j +: 4] >= 4'd5)
            begin
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4] + 4'd3;
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], sh_reg[VALUE_WIDTH-1]};
        // decimal length grows by at most one digit per step
        dig_at_cnt = '0;
        for (int j = 0; j < DEC_DIGITS; j++)
        begin
            if (dcnt_reg == DCNT_W'(j))
            begin
                dig_at_cnt = bcd_next[4*j +: 4];
            end
        end
    end

    // Text length and leading characters
    always_comb
    begin
        ndig_nat  = '0;
        ndig      = '0;
        lead_calc = '0;
        unique case (base_reg)
            BASE_DEC:
            begin
                ndig_nat  = (dcnt_reg == '0) ? LEN_BITS'(1) : LEN_BITS'(dcnt_reg);
                ndig      = ndig_nat;
                lead_calc = neg_reg ? LEN_BITS'(1) : '0;
            end
            BASE_HEX:
            begin
                ndig_nat  = found_reg ? LEN_BITS'(msb_reg >> 2) + LEN_BITS'(1) : '0;
                ndig      = (ndig_nat > prec_reg) ? ndig_nat : prec_reg;
                lead_calc = prefix_reg ? LEN_BITS'(2) : '0;
            end
            BASE_BIN:
            begin
                ndig_nat  = found_reg ? LEN_BITS'(msb_reg) + LEN_BITS'(1) : '0;
                ndig      = (ndig_nat > prec_reg) ? ndig_nat : prec_reg;
                lead_calc = prefix_reg ? LEN_BITS'(2) : '0;
            end
            default:
            begin
                ndig      = '0;
                lead_calc = '0;
            end
        endcase
        len_calc = lead_calc + ndig;
    end

    // Next output group
    always_comb
    begin
        logic [LEN_BITS-1:0] t;
        logic [LEN_BITS-1:0] idx;
        remain   = len_reg - pos_reg;
        cnt      = (remain > GROUP_LEN) ? GROUP_LEN : remain;
        pos_end  = pos_reg + cnt;
        grp_last = (pos_end >= len_reg);
        for (int k = 0; k < NUM_CHARS; k++)
        begin
            t   = pos_reg + LEN_BITS'(k);
            idx = len_reg - LEN_BITS'(1) - t;
            if (LEN_BITS'(k) >= cnt)
            begin
                grp_char[k] = '0;
            end
            else if (t < lead_reg)
            begin
                if (t == '0)
                begin
                    grp_char[k] = (base_reg == BASE_DEC) ? ASCII_MINUS : ASCII_ZERO;
                end
                else
                begin
                    grp_char[k] = (base_reg == BASE_HEX) ? ASCII_X : ASCII_B;
                end
            end
            else
            begin
                grp_char[k] = digit_char(base_reg, upper_reg, idx, bcd_reg, hex_val);
            end
        end
    end

    assign load_out = (state_reg == ST_EMIT) && (!ovalid_reg || text.ready);
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cyc_reg == BIT_LAST)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out && grp_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    base_reg   <= cmd.base;
                    neg_reg    <= cmd.neg;
                    prefix_reg <= cmd.prefix;
                    upper_reg  <= cmd.upper;
                    prec_reg   <= cmd.prec;
                    val_reg    <= cmd.magnitude[VALUE_WIDTH-1:0];
                    sh_reg     <= cmd.magnitude[VALUE_WIDTH-1:0];
                    bcd_reg    <= '0;
                    dcnt_reg   <= '0;
                    found_reg  <= 1'b0;
                    msb_reg    <= '0;
                    cyc_reg    <= '0;
                end
            end
            ST_CONV:
            begin
                sh_reg   <= sh_reg << 1;
                bcd_reg  <= bcd_next;
                cyc_reg  <= cyc_reg + BIT_W'(1);
                if (dig_at_cnt != '0)
                begin
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                end
                // first set bit seen from the top
                if (!found_reg && sh_reg[VALUE_WIDTH-1])
                begin
                    found_reg <= 1'b1;
                    msb_reg   <= BIT_LAST - cyc_reg;
                end
            end
            ST_SIZE:
            begin
                len_reg  <= len_calc;
                lead_reg <= lead_calc;
                pos_reg  <= '0;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    pos_reg <= pos_end;
                end
            end
            default:
            begin
                pos_reg <= '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int k = 0; k < NUM_CHARS; k++)
            begin
                char_reg[k] <= grp_char[k];
            end
            count_reg <= COUNT_BITS'(cnt);
            last_reg  <= grp_last;
        end
    end

    assign text.valid      = ovalid_reg;
    assign text.char0      = char_reg[0];
    assign text.char1      = char_reg[1];
    assign text.char2      = char_reg[2];
    assign text.char3      = char_reg[3];
    assign text.char_count = count_reg;
    assign text.last       = last_reg;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Integer to ASCII text formatter.
// item channel: one beat per conversion request (value, base_select, precision,
//   dec_unsigned, add_prefix, uppercase). Taken whenever the two-entry command
//   queue has room, so up to two requests can wait behind the one in progress.
// text channel: the text most significant character first, up to
//   CHARS_PER_RESULT characters per beat in char0..char3 (unused slots are 0),
//   char_count valid characters, last on the final beat. Empty text is a
//   single beat with char_count 0 and last set.
// Sequence: after the request beat is taken, the back pops the queue, runs one
//   double-dabble shift per bit, sizes the text and loads the output register.
// Converter: bit-serial, one request at a time; the next request leaves the
//   queue only after the last beat of the current one is loaded.
// Receiver stall: the output register holds its beat until ready; the
//   converter waits, and new requests keep queuing until the queue fills.
// Reset: clears the queue, the converter state and the output valid.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH      = ita_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_PRECISION    = ita_pkg::DEF_MAX_PRECISION,
    parameter int CHARS_PER_RESULT = ita_pkg::DEF_CHARS_PER_RESULT
) (
    input  logic       clk,
    input  logic       rst_n,
    ita_item_if.sink   item,
    ita_text_if.source text
);
    import ita_pkg::*;

    cmd_t push_cmd, head_cmd;
    logic push, full, pop, head_valid;

    ita_front #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front (
        .item (item),
        .full (full),
        .cmd  (push_cmd),
        .push (push)
    );

    ita_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (push_cmd),
        .full      (full),
        .pop       (pop),
        .cmd_valid (head_valid),
        .rdata     (head_cmd)
    );

    ita_back #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .CHARS_PER_RESULT (CHARS_PER_RESULT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (pop),
        .text      (text)
    );

endmodule

/* rtl/ita_checker.sv */
module ita_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_ready,
    input logic [7:0] char0,
    input logic [7:0] char1,
    input logic [7:0] char2,
    input logic [7:0] char3,
    input logic [2:0] char_count,
    input logic       last
);

    // A stalled beat keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid
            && $stable(char0) && $stable(char1) && $stable(char2) && $stable(char3)
            && $stable(char_count) && $stable(last))
        else $error("text beat changed while stalled");

    // Only the empty text produces a beat without characters
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && (char_count == 3'd0) |-> last && (char0 == 8'd0))
        else $error("empty beat not marked last or not cleared");

    // Character count never exceeds the four slots
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (char_count <= 3'd4))
        else $error("character count out of range");

    // Slot char3 is zero when the count is below four
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && (char_count < 3'd4) |-> (char3 == 8'd0))
        else $error("unused character slot not zero");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .char0      (text.char0),
    .char1      (text.char1),
    .char2      (text.char2),
    .char3      (text.char3),
    .char_count (text.char_count),
    .last       (text.last)
);

/* bench/integer_to_ascii_formatter_test.sv */
module integer_to_ascii_formatter_test;
    import ita_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 300;
    localparam int IDLE_PERCENT  = 35;
    localparam int STEADY_FIRST  = 150;     // random items sent with no idling on either side
    localparam int STEADY_LAST   = 199;
    localparam int HOLD_AT_ITEM  = 60;      // receiver backs off around this item
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 24;
    localparam int DIGITS_MAX    = 64;      // digit and pad room, prefix comes on top
    localparam int GROUP_CHARS   = DEF_CHARS_PER_RESULT;
    localparam int PREC_LIMIT    = DEF_MAX_PRECISION;

    typedef logic [CHAR_BITS-1:0] char_t;

    localparam char_t CH_UPPER_A = "A";
    localparam char_t CH_LOWER_A = "a";

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        base_t                 base;
        logic [PREC_BITS-1:0]  precision;
        logic                  dec_unsigned;
        logic                  add_prefix;
        logic                  uppercase;
    } format_req_t;

    typedef struct packed {
        char_t                 char0;
        char_t                 char1;
        char_t                 char2;
        char_t                 char3;
        logic [COUNT_BITS-1:0] char_count;
        logic                  last;
    } text_beat_t;

    // typed = 1: the row carries its expected text, else the formatter model supplies it
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        base_t                 base;
        logic [PREC_BITS-1:0]  precision;
        logic                  dec_unsigned;
        logic                  add_prefix;
        logic                  uppercase;
        logic                  typed;
        string                 text;
    } directed_row_t;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // decimal: extremes and sign handling
        '{64'd0,                  BASE_DEC,  7'd0,   1'b1, 1'b0, 1'b0, 1'b1, "0"},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_DEC,  7'd0,   1'b1, 1'b0, 1'b0, 1'b1,
          "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_DEC,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "-1"},
        '{64'h8000_0000_0000_0000, BASE_DEC,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1,
          "-9223372036854775808"},
        '{64'h7FFF_FFFF_FFFF_FFFF, BASE_DEC,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1,
          "9223372036854775807"},
        '{64'd1,                  BASE_DEC,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "1"},
        // decimal ignores precision, prefix and case
        '{64'd12345,              BASE_DEC,  7'd20,  1'b0, 1'b1, 1'b1, 1'b1, "12345"},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_DEC,  7'd127, 1'b1, 1'b1, 1'b1, 1'b0, ""},
        // zero in hex or binary, with and without padding
        '{64'd0,                  BASE_HEX,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1, ""},
        '{64'd0,                  BASE_HEX,  7'd0,   1'b0, 1'b1, 1'b0, 1'b1, "0x"},
        '{64'd0,                  BASE_BIN,  7'd0,   1'b0, 1'b1, 1'b1, 1'b1, "0b"},
        '{64'd0,                  BASE_BIN,  7'd0,   1'b0, 1'b0, 1'b0, 1'b1, ""},
        '{64'd0,                  BASE_BIN,  7'd1,   1'b0, 1'b0, 1'b0, 1'b1, "0"},
        // unsupported base gives empty text
        '{64'h1234,               BASE_NONE, 7'd0,   1'b0, 1'b0, 1'b0, 1'b1, ""},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_NONE, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, ""},
        // hex and binary extremes, case and prefix
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_HEX,  7'd0,   1'b0, 1'b0, 1'b1, 1'b1,
          "FFFFFFFFFFFFFFFF"},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_HEX,  7'd0,   1'b0, 1'b1, 1'b0, 1'b1,
          "0xffffffffffffffff"},
        '{64'hFFFF_FFFF_FFFF_FFFF, BASE_BIN,  7'd0,   1'b0, 1'b1, 1'b1, 1'b0, ""},
        '{64'd1,                  BASE_BIN,  7'd64,  1'b0, 1'b1, 1'b0, 1'b0, ""},
        // precision above the limit saturates
        '{64'd0,                  BASE_HEX,  7'd127, 1'b0, 1'b1, 1'b0, 1'b0, ""},
        '{64'h00AB_CDEF,          BASE_HEX,  7'd100, 1'b0, 1'b1, 1'b1, 1'b0, ""},
        // binary prefix stays lower case
        '{64'd5,                  BASE_BIN,  7'd0,   1'b0, 1'b1, 1'b1, 1'b1, "0b101"},
        '{64'hDEAD_BEEF,          BASE_HEX,  7'd3,   1'b0, 1'b0, 1'b0, 1'b1, "deadbeef"},
        '{64'h0123_4567_89AB_CDEF, BASE_HEX,  7'd0,   1'b1, 1'b1, 1'b1, 1'b0, ""}
    };

    logic clk = 1'b0;
    logic rst_n;

    ita_item_if item_ch ();
    ita_text_if text_ch ();

    integer_to_ascii_formatter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .text  (text_ch)
    );

    text_beat_t text_beats_due [$];
    int         fail_count    = 0;
    logic       steady_phase  = 1'b0;
    logic       hold_request  = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    // Expected text of one request, most significant character first
    function automatic void render_text(input format_req_t req, ref char_t txt [$]);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            nib;
        logic                  neg;
        int                    prec_sat;
        txt.delete();
        mag = req.value;
        case (req.base)
            BASE_DEC:
            begin
                neg = !req.dec_unsigned && mag[VALUE_BITS-1];
                if (neg)
                    mag = ~mag + 1'b1;
                do
                begin
                    txt.push_front(ASCII_ZERO + char_t'(mag % 10));
                    mag = mag / 10;
                end
                while (mag != 0);
                if (neg)
                    txt.push_front(ASCII_MINUS);
            end
            BASE_HEX, BASE_BIN:
            begin
                prec_sat = (req.precision > PREC_LIMIT) ? PREC_LIMIT : int'(req.precision);
                while (mag != 0 && txt.size() < DIGITS_MAX)
                begin
                    if (req.base == BASE_HEX)
                    begin
                        nib = mag[3:0];
                        if (nib < 4'd10)
                            txt.push_front(ASCII_ZERO + nib);
                        else
                            txt.push_front((req.uppercase ? CH_UPPER_A : CH_LOWER_A)
                                           + nib - 4'd10);
                        mag = mag >> 4;
                    end
                    else
                    begin
                        txt.push_front(ASCII_ZERO + mag[0]);
                        mag = mag >> 1;
                    end
                end
                while (txt.size() < prec_sat && txt.size() < DIGITS_MAX)
                    txt.push_front(ASCII_ZERO);
                if (req.add_prefix)
                begin
                    txt.push_front(req.base == BASE_HEX ? ASCII_X : ASCII_B);
                    txt.push_front(ASCII_ZERO);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Split text into beats; empty text is one beat with no characters
    function automatic void queue_beats(ref char_t txt [$]);
        text_beat_t beat;
        int         pos;
        int         cnt;
        pos = 0;
        if (txt.size() == 0)
        begin
            beat = '0;
            beat.last = 1'b1;
            text_beats_due.push_back(beat);
        end
        while (pos < txt.size())
        begin
            cnt = txt.size() - pos;
            if (cnt > GROUP_CHARS)
                cnt = GROUP_CHARS;
            beat = '0;
            beat.char0 = txt[pos];
            if (cnt > 1)
                beat.char1 = txt[pos + 1];
            if (cnt > 2)
                beat.char2 = txt[pos + 2];
            if (cnt > 3)
                beat.char3 = txt[pos + 3];
            beat.char_count = COUNT_BITS'(cnt);
            pos += cnt;
            beat.last = (pos == txt.size());
            text_beats_due.push_back(beat);
        end
    endfunction

    function automatic string beat_image(input text_beat_t beat);
        return $sformatf("chars %02h %02h %02h %02h count %0d last %0d", beat.char0,
                         beat.char1, beat.char2, beat.char3, beat.char_count, beat.last);
    endfunction

    // Compare a received beat against the oldest expected one
    function automatic void check_text_beat(input text_beat_t got);
        text_beat_t want;
        if (text_beats_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] unexpected text beat: %s", $time, beat_image(got));
            return;
        end
        want = text_beats_due.pop_front();
        if (got.char0 !== want.char0 || got.char1 !== want.char1 ||
            got.char2 !== want.char2 || got.char3 !== want.char3 ||
            got.char_count !== want.char_count || got.last !== want.last)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] text beat mismatch: expected %s, got %s", $time,
                         beat_image(want), beat_image(got));
        end
    endfunction

    // Random request, weighted toward corner values
    function automatic format_req_t random_request();
        format_req_t req;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            req.base = BASE_NONE;
        else if (pick < 40)
            req.base = BASE_DEC;
        else if (pick < 70)
            req.base = BASE_HEX;
        else
            req.base = BASE_BIN;
        case ($urandom_range(9))
            0:       req.value = '0;
            1:       req.value = '1;
            2:       req.value = 64'd1 << $urandom_range(63);
            3:       req.value = 64'($urandom_range(255));
            4:       req.value = 64'h8000_0000_0000_0000 + 64'($urandom_range(15));
            5:       req.value = -64'($urandom_range(1000));
            default: req.value = {$urandom, $urandom};
        endcase
        pick = $urandom_range(99);
        if (pick < 45)
            req.precision = PREC_BITS'($urandom_range(8));
        else if (pick < 75)
            req.precision = PREC_BITS'($urandom_range(64));
        else if (pick < 85)
            req.precision = PREC_BITS'(PREC_LIMIT);
        else
            req.precision = PREC_BITS'($urandom_range(127, 65));
        req.dec_unsigned = 1'($urandom_range(1));
        req.add_prefix   = 1'($urandom_range(1));
        req.uppercase    = 1'($urandom_range(1));
        return req;
    endfunction

    // Offer one request beat, with random gaps, until it is taken
    task automatic offer_item(input format_req_t req);
        while (!steady_phase && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.value        <= req.value;
        item_ch.base_select  <= req.base;
        item_ch.precision    <= req.precision;
        item_ch.dec_unsigned <= req.dec_unsigned;
        item_ch.add_prefix   <= req.add_prefix;
        item_ch.uppercase    <= req.uppercase;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
    endtask

    // Receiver: check accepted beats, toggle ready, one long back-off
    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        text_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && text_ch.valid && text_ch.ready)
                check_text_beat('{text_ch.char0, text_ch.char1, text_ch.char2, text_ch.char3,
                                  text_ch.char_count, text_ch.last});
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                text_ch.ready <= 1'b0;
            end
            else
                text_ch.ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus: reset, directed table, random requests, drain
    initial
    begin : stimulus
        format_req_t req;
        char_t       txt [$];
        int          i;
        int          k;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.value        <= '0;
        item_ch.base_select  <= BASE_DEC;
        item_ch.precision    <= '0;
        item_ch.dec_unsigned <= 1'b0;
        item_ch.add_prefix   <= 1'b0;
        item_ch.uppercase    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            req = '{directed_rows[i].value, directed_rows[i].base, directed_rows[i].precision,
                    directed_rows[i].dec_unsigned, directed_rows[i].add_prefix,
                    directed_rows[i].uppercase};
            if (directed_rows[i].typed)
            begin
                txt.delete();
                for (k = 0; k < directed_rows[i].text.len(); k++)
                    txt.push_back(directed_rows[i].text[k]);
            end
            else
                render_text(req, txt);
            offer_item(req);
            queue_beats(txt);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady_phase <= (i >= STEADY_FIRST && i <= STEADY_LAST);
            if (i == HOLD_AT_ITEM)
                hold_request <= 1'b1;
            req = random_request();
            render_text(req, txt);
            offer_item(req);
            queue_beats(txt);
        end
        item_ch.valid <= 1'b0;

        while (text_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
